>>> src/nrled_pkg.sv
// types and constants for the ntfs run list extent decoder
// no dependencies; imported by ntfs_runlist_extent_decoder_unit
package nrled_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_BASE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_SECTOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_CLUSTER = 2'd2;

    // reset values of the geometry registers
    localparam logic [15:0] BPS_RESET = 16'd512;
    localparam logic [7:0]  SPC_RESET = 8'd8;

    // header nibble mask and the byte count beyond which field bytes are dropped
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;
    localparam logic [3:0] MAX_KEPT_BYTES = 4'd8;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_LENGTH = 3'b010,
        PH_OFFSET = 3'b100
    } phase_t;

    // one result beat
    typedef struct packed {
        logic [63:0] offset;
        logic [63:0] length;
        logic        has_extent;
        logic        list_end;
    } result_t;

    // sign extend a little-endian delta of nbytes (1..8) bytes to 64 bits
    function automatic logic [63:0] sign_extend_delta(input logic [63:0] value,
                                                      input logic [3:0]  nbytes);
        logic        sign;
        logic [63:0] res;
        sign = 1'b0;
        res  = value;
        for (int i = 0; i < 8; i++) begin
            if (4'(i + 1) == nbytes) begin
                sign = value[8*i+7];
            end
        end
        for (int i = 0; i < 8; i++) begin
            if (4'(i) >= nbytes && sign) begin
                res[8*i +: 8] = 8'hFF;
            end
        end
        return res;
    endfunction

endpackage

>>> src/ntfs_runlist_extent_decoder_unit.sv
// ntfs run list decoder: bytes in, merged byte extents out
// depends on nrled_pkg (phase type, result struct, register indexes)
//
//  channel   direction  beat                     payload
//  s_axis    in         one run list byte        tdata[7:0] run_byte
//  m_axis    out        one merged extent        tdata offset/length, tuser has, tlast end
//  cfg       in         one register write       cfg_index, cfg_data
//
// takes one byte per cycle while s_axis_tready is high; the parser updates its state on the accepting edge
// a closed run or list end passes a 3 stage pipe: geometry/cluster latch,
// 32x24 partial products, offset/length sum; the merge with the pending extent
// writes the output register, or the skid register while the output stalls
// reset is synchronous; s_axis_tready drops only while the skid register holds a beat
module ntfs_runlist_extent_decoder_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] run_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [63:0] extent_offset, [127:64] extent_length
    output logic         m_axis_tuser,   // [0] has_extent
    output logic         m_axis_tlast,   // list_end
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [nrled_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]  cfg_data
);
    import nrled_pkg::*;

    // configuration registers
    logic [63:0] base_reg;
    logic [15:0] bps_reg;
    logic [7:0]  spc_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  left_reg, left_next;
    logic [3:0]  total_reg, total_next;
    logic [3:0]  idx_reg, idx_next;
    logic [63:0] len_acc_reg, len_acc_next;
    logic [63:0] dlt_acc_reg, dlt_acc_next;
    logic [63:0] clus_reg, clus_next;

    // pipe stage 1
    logic        p1_valid_reg, p1_end_reg;
    logic [63:0] p1_clus_reg, p1_runlen_reg, p1_base_reg;
    logic [23:0] p1_cb_reg;
    // pipe stage 2
    logic        p2_valid_reg, p2_end_reg;
    logic [55:0] p2_clo_reg, p2_llo_reg;
    logic [31:0] p2_chi_reg, p2_lhi_reg;
    logic [63:0] p2_base_reg;
    // pipe stage 3
    logic        p3_valid_reg, p3_end_reg;
    logic [63:0] p3_off_reg, p3_len_reg;

    // pending extent
    logic        pend_valid_reg;
    logic [63:0] pend_off_reg, pend_len_reg, pend_end_reg;

    // output register and skid register
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic        adv;
    logic        in_acc;
    logic [63:0] byte_sh;
    logic [63:0] len_ins, dlt_ins, dlt_ext;
    logic [3:0]  nbytes;
    logic [4:0]  idx_inc;
    logic        tok_valid, tok_end;
    logic [23:0] cb_w;
    logic [55:0] clo_w, llo_w;
    logic [31:0] chi_w, lhi_w;
    logic        merge_go;
    logic        res_valid;
    result_t     res;
    logic [63:0] off_plus_len;

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            bps_reg  <= BPS_RESET;
            spc_reg  <= SPC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PARTITION_BASE:      base_reg <= cfg_data;
                CFG_BYTES_PER_SECTOR:    bps_reg  <= cfg_data[15:0];
                CFG_SECTORS_PER_CLUSTER: spc_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // field byte placement and delta sign extension
    assign byte_sh = {56'd0, s_axis_tdata} << {idx_reg[2:0], 3'b000};
    assign len_ins = idx_reg[3] ? len_acc_reg : (len_acc_reg | byte_sh);
    assign dlt_ins = idx_reg[3] ? dlt_acc_reg : (dlt_acc_reg | byte_sh);
    assign nbytes  = (total_reg >= MAX_KEPT_BYTES) ? MAX_KEPT_BYTES : total_reg;
    assign dlt_ext = sign_extend_delta(dlt_ins, nbytes);
    assign idx_inc = {1'b0, idx_reg} + 5'd1;

    // byte parser
    always_comb begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        len_acc_next = len_acc_reg;
        dlt_acc_next = dlt_acc_reg;
        clus_next    = clus_reg;
        tok_valid    = 1'b0;
        tok_end      = 1'b0;
        if (in_acc) begin
            case (phase_reg)
                PH_LENGTH: begin
                    len_acc_next = len_ins;
                    idx_next     = idx_inc[3:0];
                    left_next    = left_reg - 4'd1;
                    if (left_reg == 4'd1) begin
                        idx_next   = '0;
                        phase_next = (total_reg == 4'd0) ? PH_HEADER : PH_OFFSET;
                    end
                end
                PH_OFFSET: begin
                    dlt_acc_next = dlt_ins;
                    idx_next     = idx_inc[3:0];
                    if (idx_inc >= {1'b0, total_reg}) begin
                        tok_valid  = 1'b1;
                        clus_next  = clus_reg + dlt_ext;
                        phase_next = PH_HEADER;
                    end
                end
                default: begin
                    if ((s_axis_tdata & NIBBLE_MASK) == 8'd0) begin
                        // end of list
                        tok_valid    = 1'b1;
                        tok_end      = 1'b1;
                        phase_next   = PH_HEADER;
                        left_next    = '0;
                        total_next   = '0;
                        idx_next     = '0;
                        len_acc_next = '0;
                        dlt_acc_next = '0;
                        clus_next    = '0;
                    end else begin
                        left_next    = s_axis_tdata[3:0];
                        total_next   = s_axis_tdata[7:4];
                        idx_next     = '0;
                        len_acc_next = '0;
                        dlt_acc_next = '0;
                        phase_next   = PH_LENGTH;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            left_reg  <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
            clus_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            clus_reg  <= clus_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_acc_reg <= len_acc_next;
        dlt_acc_reg <= dlt_acc_next;
    end

    // stage 1: latch cluster, run length and geometry
    assign cb_w = {8'd0, bps_reg} * {16'd0, spc_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= tok_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tok_valid) begin
            p1_end_reg    <= tok_end;
            p1_clus_reg   <= clus_next;
            p1_runlen_reg <= len_acc_reg;
            p1_cb_reg     <= cb_w;
            p1_base_reg   <= base_reg;
        end
    end

    // stage 2: partial products, cluster and run length by cluster bytes
    assign clo_w = {24'd0, p1_clus_reg[31:0]} * {32'd0, p1_cb_reg};
    assign chi_w = p1_clus_reg[63:32] * {8'd0, p1_cb_reg};
    assign llo_w = {24'd0, p1_runlen_reg[31:0]} * {32'd0, p1_cb_reg};
    assign lhi_w = p1_runlen_reg[63:32] * {8'd0, p1_cb_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && p1_valid_reg) begin
            p2_end_reg  <= p1_end_reg;
            p2_clo_reg  <= clo_w;
            p2_chi_reg  <= chi_w;
            p2_llo_reg  <= llo_w;
            p2_lhi_reg  <= lhi_w;
            p2_base_reg <= p1_base_reg;
        end
    end

    // stage 3: byte offset and byte length, modulo 2^64
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (adv) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && p2_valid_reg) begin
            p3_end_reg <= p2_end_reg;
            p3_off_reg <= p2_base_reg + {8'd0, p2_clo_reg} + {p2_chi_reg, 32'd0};
            p3_len_reg <= {8'd0, p2_llo_reg} + {p2_lhi_reg, 32'd0};
        end
    end

    // merge with the pending extent, flush on a gap or at list end
    assign merge_go     = adv && p3_valid_reg;
    assign off_plus_len = p3_off_reg + p3_len_reg;

    always_comb begin
        res_valid      = 1'b0;
        res.offset     = pend_off_reg;
        res.length     = pend_len_reg;
        res.has_extent = 1'b1;
        res.list_end   = 1'b0;
        if (merge_go) begin
            if (p3_end_reg) begin
                res_valid    = 1'b1;
                res.list_end = 1'b1;
                if (!pend_valid_reg) begin
                    res.offset     = '0;
                    res.length     = '0;
                    res.has_extent = 1'b0;
                end
            end else if (pend_valid_reg && (pend_end_reg != p3_off_reg)) begin
                res_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (merge_go) begin
            pend_valid_reg <= !p3_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (merge_go && !p3_end_reg) begin
            if (pend_valid_reg && (pend_end_reg == p3_off_reg)) begin
                pend_len_reg <= pend_len_reg + p3_len_reg;
                pend_end_reg <= pend_end_reg + p3_len_reg;
            end else begin
                pend_off_reg <= p3_off_reg;
                pend_len_reg <= p3_len_reg;
                pend_end_reg <= off_plus_len;
            end
        end
    end

    // output register with skid, skid only fills while the output stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_axis_tready) begin
            if (res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_axis_tready) begin
            if (res_valid) begin
                skid_reg <= res;
            end
        end else if (skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.length, out_reg.offset};
    assign m_axis_tuser  = out_reg.has_extent;
    assign m_axis_tlast  = out_reg.list_end;

    // skid never holds a beat unless the output register does
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // a beat without an extent is only the list end beat
    a_empty_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty extent beat without list end");

    // the list end clears the pending extent
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (merge_go && p3_end_reg) |=> !pend_valid_reg)
        else $error("pending extent survived list end");

    // a run beat always follows a pending extent that was flushed
    a_flush_from_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res.list_end) |-> (pend_valid_reg && !p3_end_reg))
        else $error("run beat without a pending extent");

endmodule
